/* rtl/fba_pkg.sv */
package fba_pkg;

   localparam int MAP_BYTES_DEF = 512;
   localparam int WORD_BITS     = 64;
   localparam int BITPOS_W      = $clog2(WORD_BITS);
   localparam int GROUP_BITS    = 8;
   localparam int GROUPS        = WORD_BITS / GROUP_BITS;
   localparam int GROUP_SEL_W   = $clog2(GROUPS);
   localparam int GROUP_POS_W   = $clog2(GROUP_BITS);
   localparam int LIMIT_W       = 13;
   localparam int INDEX_W       = 12;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

endpackage

/* rtl/fba_if.sv */
interface fba_req_if;
   logic                           valid;
   logic                           ready;
   fba_pkg::cmd_type               cmd;
   logic [fba_pkg::INDEX_W-1:0]    block_index;

   modport source (output valid, output cmd, output block_index, input ready);
   modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

interface fba_rsp_if;
   logic                           valid;
   logic                           ready;
   fba_pkg::status_type            status;
   logic [fba_pkg::INDEX_W-1:0]    granted_index;

   modport source (output valid, output status, output granted_index, input ready);
   modport sink   (input valid, input status, input granted_index, output ready);
endinterface

interface fba_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fba_pkg::LIMIT_W-1:0]    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/first_fit_bitmap_allocator.sv */
// First-fit block allocator over a used/free bitmap held in a RAM of 64-bit words, one bit
// per block. An allocate word returns the lowest free block below min(block_limit,
// MAP_BYTES*8) and marks it used, or reports full; a free word clears one block's bit and
// flags an index at or above that count. The bitmap RAM delivers one word per cycle, which
// sets the rate: an allocate reads at most W words, W being the number of words that hold
// managed blocks (64 at the default size), and a free reads one word and writes it back.
// After reset the block clears all MAP_BYTES*8/64 RAM words (rounded up) before it takes the
// first request; block_limit may be written at any idle time, including during that pass.
module first_fit_bitmap_allocator #(
   parameter int MAP_BYTES = fba_pkg::MAP_BYTES_DEF
) (
   input logic      clock,
   input logic      reset,
   fba_req_if.sink  req_ch,
   fba_rsp_if.source rsp_ch,
   fba_csr_if.sink  csr_ch
);

   localparam int WB       = fba_pkg::WORD_BITS;
   localparam int PW       = fba_pkg::BITPOS_W;
   localparam int MAP_BITS = MAP_BYTES * 8;
   localparam int WORDS    = (MAP_BITS + WB - 1) / WB;
   localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BIT_W    = ADDR_W + PW;
   localparam int LIM_W    = BIT_W + 1;
   localparam int CW       = (LIM_W > fba_pkg::LIMIT_W) ? LIM_W : fba_pkg::LIMIT_W;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_FREE_WR = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [fba_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic [ADDR_W-1:0]             clr_ff, clr_in;
   logic [ADDR_W:0]               rd_addr_ff, rd_addr_in;
   logic [ADDR_W-1:0]             chk_addr_ff, chk_addr_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [PW-1:0]                 free_pos_ff, free_pos_in;
   fba_pkg::status_type           res_status_ff, res_status_in;
   logic [fba_pkg::INDEX_W-1:0]   res_index_ff, res_index_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   fba_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [fba_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [WB-1:0]     wr_data, rd_data;

   logic [CW-1:0]     lim_ext, cap_ext, eff_wide, idx_ext, grant_ext;
   logic [LIM_W-1:0]  eff_lim, lim_m1;
   logic [ADDR_W-1:0] last_word;
   logic [WB-1:0]     mask, cand, one_hot;
   logic [fba_pkg::GROUPS-1:0]          grp_any;
   logic [fba_pkg::GROUP_SEL_W-1:0]     grp_sel;
   logic [fba_pkg::GROUP_BITS-1:0]      grp_word;
   logic [fba_pkg::GROUP_POS_W-1:0]     bit_sel;
   logic [PW-1:0]     hit_pos;
   logic              hit;

   assign lim_ext   = CW'(limit_ff);
   assign cap_ext   = CW'(MAP_BITS);
   assign eff_wide  = (lim_ext < cap_ext) ? lim_ext : cap_ext;
   assign eff_lim   = eff_wide[LIM_W-1:0];
   assign lim_m1    = eff_lim - LIM_W'(1);
   assign last_word = lim_m1[BIT_W-1:PW];
   assign idx_ext   = CW'(req_ch.block_index);

   always_comb begin
      for (int j = 0; j < WB; j++) begin
         mask[j] = (chk_addr_ff < last_word) ||
                   ((chk_addr_ff == last_word) && (PW'(j) <= lim_m1[PW-1:0]));
      end
      cand = ~rd_data & mask;
   end

   always_comb begin
      for (int g = 0; g < fba_pkg::GROUPS; g++) begin
         grp_any[g] = |cand[g*fba_pkg::GROUP_BITS +: fba_pkg::GROUP_BITS];
      end
      grp_sel = '0;
      for (int g = fba_pkg::GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_sel = fba_pkg::GROUP_SEL_W'(g);
         end
      end
      grp_word = cand[grp_sel*fba_pkg::GROUP_BITS +: fba_pkg::GROUP_BITS];
      bit_sel = '0;
      for (int b = fba_pkg::GROUP_BITS - 1; b >= 0; b--) begin
         if (grp_word[b]) begin
            bit_sel = fba_pkg::GROUP_POS_W'(b);
         end
      end
      hit     = |grp_any;
      hit_pos = {grp_sel, bit_sel};
   end

   assign grant_ext = CW'({chk_addr_ff, hit_pos});

   always_comb begin
      one_hot = {{(WB-1){1'b0}}, 1'b1} << (state_ff == ST_FREE_WR ? free_pos_ff : hit_pos);
   end

   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      clr_in        = clr_ff;
      rd_addr_in    = rd_addr_ff;
      chk_addr_in   = chk_addr_ff;
      chk_vld_in    = chk_vld_ff;
      free_pos_in   = free_pos_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_addr_ff;
      wr_data       = rd_data | one_hot;
      rd_en         = 1'b0;
      rd_addr       = rd_addr_ff[ADDR_W-1:0];

      if (csr_ch.valid) begin
         limit_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               res_index_in = '0;
               if (req_ch.cmd == fba_pkg::CMD_ALLOC) begin
                  if (eff_lim == '0) begin
                     res_status_in = fba_pkg::STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     rd_addr_in = '0;
                     chk_vld_in = 1'b0;
                     state_in   = ST_SCAN;
                  end
               end else if (idx_ext >= CW'(eff_lim)) begin
                  res_status_in = fba_pkg::STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  rd_en         = 1'b1;
                  rd_addr       = idx_ext[BIT_W-1:PW];
                  chk_addr_in   = idx_ext[BIT_W-1:PW];
                  free_pos_in   = req_ch.block_index[PW-1:0];
                  res_status_in = fba_pkg::STATUS_OK;
                  state_in      = ST_FREE_WR;
               end
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && hit) begin
               wr_en         = 1'b1;
               res_status_in = fba_pkg::STATUS_OK;
               res_index_in  = grant_ext[fba_pkg::INDEX_W-1:0];
               chk_vld_in    = 1'b0;
               state_in      = ST_DONE;
            end else if (chk_vld_ff && (chk_addr_ff == last_word)) begin
               res_status_in = fba_pkg::STATUS_FULL;
               res_index_in  = '0;
               chk_vld_in    = 1'b0;
               state_in      = ST_DONE;
            end else if (rd_addr_ff <= {1'b0, last_word}) begin
               rd_en       = 1'b1;
               chk_addr_in = rd_addr_ff[ADDR_W-1:0];
               chk_vld_in  = 1'b1;
               rd_addr_in  = rd_addr_ff + (ADDR_W+1)'(1);
            end else begin
               chk_vld_in = 1'b0;
            end
         end
         ST_FREE_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data & ~one_hot;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         limit_ff     <= fba_pkg::LIMIT_RESET;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= rd_addr_in;
      chk_addr_ff   <= chk_addr_in;
      free_pos_ff   <= free_pos_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   fba_ram #(
      .WIDTH (WB),
      .DEPTH (WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.granted_index = rsp_index_ff;

endmodule

/* rtl/fba_ram.sv */
module fba_ram #(
   parameter int WIDTH = fba_pkg::WORD_BITS,
   parameter int DEPTH = fba_pkg::MAP_BYTES_DEF / 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
